@@ src/divider_and_reload_timer_top_defines.svh @@
// Assertion macros shared by the divider and reload timer RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef DIVIDER_AND_RELOAD_TIMER_TOP_DEFINES_SVH
`define DIVIDER_AND_RELOAD_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define DRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: ante |-> cons");

// Next-cycle implication, disabled while reset is low
`define DRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: ante |=> cons");

`endif

@@ src/drt_pkg.sv @@
// Shared types, codes and the period table of the divider and reload timer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package drt_pkg;

    // Item kinds carried in the input tuser
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
    localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
    localparam logic [1:0] REG_RELOAD_VALUE = 2'd2;

    localparam int ACC_W       = 11;
    localparam int DIV_W       = 16;
    localparam int CNT_W       = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Largest value the accumulator can hold: 1023 left over plus 255 new cycles
    localparam logic [ACC_W-1:0] ACC_LIMIT = 11'd1278;

    // Control from the sequencer to the step unit
    typedef struct packed {
        logic load_acc;   // add the tick's cycles into the accumulator
        logic step;       // try one compare-subtract step
        logic load_count; // write the counter from the item
    } drt_ctrl_t;

    // Status from the step unit back to the sequencer
    typedef struct packed {
        logic             can_step; // accumulator holds at least one period
        logic             overflow; // a step now would wrap the counter
        logic [CNT_W-1:0] count;
        logic [ACC_W-1:0] acc;
    } drt_stat_t;

    // Cycles per counter step for each clock select code
    function automatic logic [ACC_W-1:0] period_of(input logic [1:0] sel);
        logic [ACC_W-1:0] p;
        case (sel)
            2'd0:    p = 11'd1024;
            2'd1:    p = 11'd16;
            2'd2:    p = 11'd64;
            2'd3:    p = 11'd256;
            default: p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

@@ src/drt_divider.sv @@
// Free-running 16-bit divider: adds tick cycles, cleared on request.
// Depends on drt_pkg.
`timescale 1ns / 1ps

module drt_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      add_en,
    input  logic                      clear_en,
    input  logic [7:0]                cycles,
    output logic [7:0]                div_hi
);

    logic [drt_pkg::DIV_W-1:0] div_reg;
    logic [drt_pkg::DIV_W-1:0] div_next;

    // wraps modulo 2^16
    always_comb begin
        div_next = div_reg;
        if (clear_en) begin
            div_next = '0;
        end else if (add_en) begin
            div_next = div_reg + {8'd0, cycles};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= '0;
        end else begin
            div_reg <= div_next;
        end
    end

    assign div_hi = div_reg[15:8];

endmodule

@@ src/drt_step_unit.sv @@
// Prescale accumulator and 8-bit counter with one shared compare-subtract unit.
// Depends on drt_pkg; driven one step a cycle by the top-level sequencer.
`timescale 1ns / 1ps

module drt_step_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  drt_pkg::drt_ctrl_t          ctrl,
    input  logic [7:0]                  cycles,
    input  logic [7:0]                  load_value,
    input  logic [1:0]                  clock_select,
    input  logic [7:0]                  reload_value,
    output drt_pkg::drt_stat_t          stat
);

    logic [drt_pkg::ACC_W-1:0] acc_reg;
    logic [drt_pkg::ACC_W-1:0] acc_next;
    logic [drt_pkg::CNT_W-1:0] count_reg;
    logic [drt_pkg::CNT_W-1:0] count_next;
    logic [drt_pkg::ACC_W-1:0] period;
    logic                      can_step;

    // shared compare against the selected period
    assign period   = drt_pkg::period_of(clock_select);
    assign can_step = (acc_reg >= period);

    always_comb begin
        acc_next   = acc_reg;
        count_next = count_reg;
        if (ctrl.load_acc) begin
            acc_next = acc_reg + {3'd0, cycles};
        end else if (ctrl.step && can_step) begin
            acc_next = acc_reg - period;
            // wrap reloads from the reload register
            if (count_reg == drt_pkg::CNT_MAX) begin
                count_next = reload_value;
            end else begin
                count_next = count_reg + 8'd1;
            end
        end
        if (ctrl.load_count) begin
            count_next = load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            count_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    assign stat.can_step = can_step;
    assign stat.overflow = can_step && (count_reg == drt_pkg::CNT_MAX);
    assign stat.count    = count_reg;
    assign stat.acc      = acc_reg;

endmodule

@@ src/divider_and_reload_timer_top.sv @@
// Divider and reload timer: an item arrives as a word with its kind in tuser
// (tick, clear divider, load counter) and leaves one result word. A clear, a
// load, an unused kind or a tick with the timer off goes from accept through
// the emit state into the output register: the block takes the next word on
// the cycle after the result is registered, provided the output register is
// free or drains in that cycle. A tick with the timer on passes through the
// run state, where it makes its counter steps, and then the emit state:
// the step unit does one compare-subtract of the prescale accumulator per
// cycle. Configuration writes take effect at once and are meant for idle
// periods only.
// Depends on drt_pkg, drt_divider, drt_step_unit and the defines header.
`timescale 1ns / 1ps
`include "divider_and_reload_timer_top_defines.svh"

module divider_and_reload_timer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [drt_pkg::S_TDATA_W-1:0]     s_tdata,  // cycles[7:0], value[15:8]
    input  logic [drt_pkg::S_TUSER_W-1:0]     s_tuser,  // func[1:0]
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [drt_pkg::M_TDATA_W-1:0]     m_tdata,  // div_value[7:0],
                                                        // counter_value[15:8],
                                                        // irq_request[16], zero
    // configuration
    input  logic                              cfg_we,
    input  logic [drt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [drt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                timer_enable_reg;
    logic [1:0]          clock_select_reg;
    logic [7:0]          reload_value_reg;
    logic                irq_reg;
    logic                m_tvalid_reg;
    logic [7:0]          m_div_reg;
    logic [7:0]          m_count_reg;
    logic                m_irq_reg;

    logic                in_accept;
    logic [1:0]          func;
    logic [7:0]          cycles;
    logic [7:0]          value;
    logic [7:0]          div_hi;
    logic                is_tick;
    drt_pkg::drt_ctrl_t  ctrl;
    drt_pkg::drt_stat_t  stat;

    assign func   = s_tuser[1:0];
    assign cycles = s_tdata[7:0];
    assign value  = s_tdata[15:8];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign is_tick   = (func == drt_pkg::FUNC_TICK);

    // control to the step unit
    assign ctrl.load_acc   = in_accept && is_tick && timer_enable_reg;
    assign ctrl.step       = (state_reg == ST_RUN);
    assign ctrl.load_count = in_accept && (func == drt_pkg::FUNC_LOAD);

    drt_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .add_en   (in_accept && is_tick),
        .clear_en (in_accept && (func == drt_pkg::FUNC_CLEAR)),
        .cycles   (cycles),
        .div_hi   (div_hi)
    );

    drt_step_unit u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .cycles       (cycles),
        .load_value   (value),
        .clock_select (clock_select_reg),
        .reload_value (reload_value_reg),
        .stat         (stat)
    );

    // sequencer, configuration registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            timer_enable_reg <= 1'b0;
            clock_select_reg <= 2'd0;
            reload_value_reg <= 8'd0;
            irq_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    drt_pkg::REG_TIMER_ENABLE: timer_enable_reg <= cfg_wdata[0];
                    drt_pkg::REG_CLOCK_SELECT: clock_select_reg <= cfg_wdata[1:0];
                    drt_pkg::REG_RELOAD_VALUE: reload_value_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        irq_reg <= 1'b0;
                        if (is_tick && timer_enable_reg) begin
                            state_reg <= ST_RUN;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_RUN: begin
                    // one period off the accumulator per cycle
                    if (stat.can_step) begin
                        irq_reg <= irq_reg | stat.overflow;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    m_div_reg    <= div_hi;
                    m_count_reg  <= stat.count;
                    m_irq_reg    <= irq_reg;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_irq_reg, m_count_reg, m_div_reg};

    // checks
    `DRT_ASSERT_IMPL(a_run_out_free, aclk, aresetn, state_reg != ST_IDLE, !m_tvalid_reg)
    `DRT_ASSERT_NEXT(a_run_ends, aclk, aresetn,
        (state_reg == ST_RUN) && !stat.can_step, state_reg == ST_EMIT)
    `DRT_ASSERT_IMPL(a_acc_bound, aclk, aresetn, 1'b1, stat.acc <= drt_pkg::ACC_LIMIT)
    `DRT_ASSERT_NEXT(a_idle_count_hold, aclk, aresetn,
        (state_reg == ST_IDLE) && !in_accept, $stable(stat.count))

endmodule

@@ bench/divider_and_reload_timer_top_tb.sv @@
// Self-checking bench for divider_and_reload_timer_top: directed and random
// word streams checked against an in-bench timer predictor. Needs drt_pkg and the RTL only.
`timescale 1ns / 1ps

module divider_and_reload_timer_top_tb;

    // kinds and rate codes not named by the package
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] SEL_1024    = 2'd0;
    localparam logic [1:0] SEL_16      = 2'd1;
    localparam logic [1:0] SEL_64      = 2'd2;
    localparam logic [1:0] SEL_256     = 2'd3;

    localparam int STALL_LIMIT   = 1000;  // cycles with no word moving on either side
    localparam int PHASE_WORDS   = 60;
    localparam int RANDOM_PHASES = 14;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] cycles;
        logic [7:0] value;
    } timer_word_t;

    typedef struct packed {
        logic       irq;
        logic [7:0] count;
        logic [7:0] div;
    } timer_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [drt_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [drt_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [drt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [drt_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [drt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    divider_and_reload_timer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // predictor state and its copy of the registers
    logic [15:0] tm_divider = '0;
    logic [10:0] tm_acc     = '0;
    logic [7:0]  tm_count   = '0;
    logic        tm_enable  = 1'b0;
    logic [1:0]  tm_select  = SEL_1024;
    logic [7:0]  tm_reload  = '0;

    timer_word_t   words_to_send[$];
    timer_result_t results_due[$];

    bit src_gaps_on   = 1'b0;
    bit sink_stalls_on = 1'b0;
    int src_wait  = 0;
    int sink_wait = 0;

    int mismatches   = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int irqs_seen    = 0;
    int settings_run = 1;
    int kind_seen[4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    // Apply one word to the predictor and return the result it should give
    function automatic timer_result_t advance_timer(input timer_word_t w);
        timer_result_t r;
        int unsigned   period;
        int unsigned   acc;
        r.irq = 1'b0;
        case (w.func)
            drt_pkg::FUNC_TICK: begin
                tm_divider = tm_divider + 16'(w.cycles);
                if (tm_enable) begin
                    case (tm_select)
                        SEL_16:  period = 16;
                        SEL_64:  period = 64;
                        SEL_256: period = 256;
                        default: period = 1024;
                    endcase
                    acc = tm_acc + w.cycles;
                    // one counter step per whole period held
                    while (acc >= period) begin
                        acc = acc - period;
                        if (tm_count == 8'hFF) begin
                            tm_count = tm_reload;
                            r.irq    = 1'b1;
                        end else begin
                            tm_count = tm_count + 8'd1;
                        end
                    end
                    tm_acc = acc[10:0];
                end
            end
            drt_pkg::FUNC_CLEAR: tm_divider = '0;
            drt_pkg::FUNC_LOAD:  tm_count   = w.value;
            default: ;
        endcase
        r.div   = tm_divider[15:8];
        r.count = tm_count;
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Source side: presents queued words, predicts each on acceptance
    always @(posedge aclk) begin : source_drive
        timer_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                w.func   = s_tuser;
                w.cycles = s_tdata[7:0];
                w.value  = s_tdata[15:8];
                results_due.push_back(advance_timer(w));
                kind_seen[w.func]++;
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait != 0) begin
                    src_wait <= src_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    w = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {w.value, w.cycles};
                    s_tuser  <= w.func;
                    src_wait <= src_gaps_on ? $urandom_range(0, 12) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random back-pressure, checks every result word
    always @(posedge aclk) begin : sink_check
        timer_result_t want;
        int            w;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[16])
                irqs_seen++;
            if (results_due.size() == 0) begin
                note_mismatch($sformatf("result word %h with nothing expected", m_tdata));
            end else begin
                want = results_due.pop_front();
                if (m_tdata[7:0] !== want.div || m_tdata[15:8] !== want.count ||
                    m_tdata[16] !== want.irq)
                    note_mismatch($sformatf(
                        "div %h/%h count %h/%h irq %b/%b (expected/actual)",
                        want.div, m_tdata[7:0], want.count, m_tdata[15:8],
                        want.irq, m_tdata[16]));
            end
            w = sink_stalls_on ? $urandom_range(0, 12) : 0;
            sink_wait <= w;
            m_tready  <= (w == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("divider_and_reload_timer_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_word(input logic [1:0] func, input logic [7:0] cycles,
                              input logic [7:0] value);
        timer_word_t w;
        w.func   = func;
        w.cycles = cycles;
        w.value  = value;
        words_to_send.push_back(w);
    endtask

    // Block is idle once nothing is queued, presented or outstanding
    task automatic wait_idle();
        @(negedge aclk);
        while (words_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            drt_pkg::REG_TIMER_ENABLE: tm_enable = data[0];
            drt_pkg::REG_CLOCK_SELECT: tm_select = data[1:0];
            drt_pkg::REG_RELOAD_VALUE: tm_reload = data;
            default: ;
        endcase
    endtask

    task automatic set_timer(input logic en, input logic [1:0] sel, input logic [7:0] reload);
        wait_idle();
        write_reg(drt_pkg::REG_TIMER_ENABLE, {7'd0, en});
        write_reg(drt_pkg::REG_CLOCK_SELECT, {6'd0, sel});
        write_reg(drt_pkg::REG_RELOAD_VALUE, reload);
        settings_run++;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int          counted;
        int          pick;
        logic [1:0]  f;
        logic [7:0]  c;
        logic [7:0]  v;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: timer off, so no counter steps; only the divider moves and loads set the counter
        @(negedge aclk);
        queue_word(drt_pkg::FUNC_TICK, 8'd0, 8'h00);
        queue_word(drt_pkg::FUNC_TICK, 8'd255, 8'hFF);
        queue_word(drt_pkg::FUNC_TICK, 8'd1, 8'h00);
        queue_word(drt_pkg::FUNC_CLEAR, 8'd255, 8'hFF);
        queue_word(drt_pkg::FUNC_LOAD, 8'd0, 8'hFF);
        queue_word(FUNC_UNUSED, 8'hFF, 8'hFF);
        queue_word(drt_pkg::FUNC_LOAD, 8'd255, 8'h00);

        // fastest rate, overflow reloads to the top value
        set_timer(1'b1, SEL_16, 8'hFF);
        queue_word(drt_pkg::FUNC_LOAD, 8'd0, 8'hFE);
        queue_word(drt_pkg::FUNC_TICK, 8'd255, 8'h00);
        queue_word(drt_pkg::FUNC_TICK, 8'd0, 8'h00);
        queue_word(drt_pkg::FUNC_TICK, 8'd15, 8'h00);
        queue_word(drt_pkg::FUNC_TICK, 8'd1, 8'h00);
        queue_word(FUNC_UNUSED, 8'd200, 8'h55);
        queue_word(drt_pkg::FUNC_LOAD, 8'd0, 8'hFF);
        queue_word(drt_pkg::FUNC_TICK, 8'd16, 8'h00);

        // slowest rate, let the accumulator fill up
        set_timer(1'b1, SEL_1024, 8'h00);
        queue_word(drt_pkg::FUNC_LOAD, 8'd0, 8'hFF);
        repeat (4) queue_word(drt_pkg::FUNC_TICK, 8'd250, 8'h00);
        queue_word(drt_pkg::FUNC_TICK, 8'd30, 8'h00);

        // timer off holds the accumulator, then a zero tick runs it against a lowered period
        set_timer(1'b0, SEL_1024, 8'h80);
        queue_word(drt_pkg::FUNC_TICK, 8'd255, 8'h00);
        set_timer(1'b1, SEL_16, 8'h80);
        queue_word(drt_pkg::FUNC_TICK, 8'd0, 8'h00);

        // random phases with random settings and handshake pressure
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_timer($urandom_range(0, 4) != 0, 2'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
            src_gaps_on    = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
            counted = 0;
            while (counted < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 72)      f = drt_pkg::FUNC_TICK;
                else if (pick < 84) f = drt_pkg::FUNC_LOAD;
                else if (pick < 93) f = drt_pkg::FUNC_CLEAR;
                else                f = FUNC_UNUSED;
                case ($urandom_range(0, 9))
                    0:       c = 8'd0;
                    1:       c = 8'd255;
                    2, 3, 4, 5: c = 8'($urandom_range(4, 24));
                    default: c = 8'($urandom_range(0, 255));
                endcase
                v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                : 8'($urandom_range(0, 255));
                queue_word(f, c, v);
                counted++;
            end
        end

        wait_idle();
        repeat (100) @(negedge aclk);
        if (results_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("covered %0d words (tick %0d, clear %0d, load %0d, unused %0d)",
                 words_sent, kind_seen[drt_pkg::FUNC_TICK], kind_seen[drt_pkg::FUNC_CLEAR],
                 kind_seen[drt_pkg::FUNC_LOAD], kind_seen[FUNC_UNUSED]);
        $display("%0d settings, %0d results checked, %0d with interrupt request, %0d mismatches",
                 settings_run, results_seen, irqs_seen, mismatches);
        if (mismatches == 0)
            $display("divider_and_reload_timer_top_tb: PASS");
        else
            $display("divider_and_reload_timer_top_tb: FAIL");
        $finish;
    end

endmodule
